// File: rtl/tlfo_pkg.sv
// shared types, constants and lookup tables of the tremolo block
package tlfo_pkg;

    localparam int COS_TABLE_BITS = 10;
    localparam int EXP_TABLE_BITS = 8;
    localparam int COS_QUARTER    = 1 << (COS_TABLE_BITS - 2);
    localparam int EXP_SIZE       = 1 << EXP_TABLE_BITS;
    localparam int COS_SHIFT      = 32 - COS_TABLE_BITS;
    localparam int EXP_SHIFT      = 12 - EXP_TABLE_BITS;
    localparam int MUL_W          = 27;
    localparam int PROD_W         = 2 * MUL_W;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam logic [16:0] FULL        = 17'd65536;
    localparam logic [13:0] RATE_MAX    = 14'd14336;
    localparam logic signed [15:0] TRIG_HIGH = 16'sd3277;

    localparam logic [2:0] REG_RATE  = 3'd0;
    localparam logic [2:0] REG_WAVE  = 3'd1;
    localparam logic [2:0] REG_BLEND = 3'd2;
    localparam logic [2:0] REG_PHASE = 3'd3;
    localparam logic [2:0] REG_STEP  = 3'd4;
    localparam logic [2:0] REG_FADE  = 3'd5;

    typedef struct packed {
        logic [13:0] rate_knob;
        logic [16:0] wave_knob;
        logic [16:0] blend_knob;
        logic        phase_switch;
        logic [23:0] phase_step_per_hz;
        logic [16:0] fade_step;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] x;
        logic [20:0]        freq;
        logic [16:0]        wave;
        logic [16:0]        blend;
        logic               toggle;
    } t_item;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_FREQ  = 10'b0000000010,
        ST_PHASE = 10'b0000000100,
        ST_COS   = 10'b0000001000,
        ST_WAVE  = 10'b0000010000,
        ST_TREM  = 10'b0000100000,
        ST_MIX   = 10'b0001000000,
        ST_DRY   = 10'b0010000000,
        ST_FX    = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } t_state;

    typedef logic [17:0] t_exp_rom [EXP_SIZE + 1];
    typedef logic [16:0] t_cos_rom [COS_QUARTER + 1];

    function automatic t_exp_rom f_build_exp();
        t_exp_rom    rom;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        for (int j = 0; j <= EXP_SIZE; j++) begin
            y    = (64'(j) * LN2_Q30) >> EXP_TABLE_BITS;
            term = 64'd1 << 30;
            sum  = term;
            for (int k = 1; k <= 16; k++) begin
                term = ((term * y) >> 30) / 64'(k);
                sum  = sum + term;
            end
            rom[j] = 18'((sum + 64'd8192) >> 14);
        end
        return rom;
    endfunction

    function automatic t_cos_rom f_build_cos();
        t_cos_rom           rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        for (int i = 0; i <= COS_QUARTER; i++) begin
            x    = (64'(i) * HALF_PI_Q30) / 64'(COS_QUARTER);
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = 64'sd1 <<< 30;
            for (int k = 1; k <= 10; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum <= 0) begin
                rom[i] = 17'd0;
            end else begin
                r = (sum + 64'sd8192) >>> 14;
                if (r > 64'sd65536) begin
                    r = 64'sd65536;
                end
                rom[i] = 17'(r);
            end
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = f_build_exp();
    localparam t_cos_rom COS_ROM = f_build_cos();

endpackage

// File: rtl/tlfo_front.sv
// front end: takes input beats, runs the bypass edge detectors and control clamps
module tlfo_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_audio_in,
    input  logic signed [15:0]    i_wave_cv,
    input  logic signed [15:0]    i_rate_cv,
    input  logic signed [15:0]    i_blend_cv,
    input  logic signed [15:0]    i_bypass_cv,
    input  logic                  i_bypass_button,
    input  tlfo_pkg::t_cfg        i_cfg,
    input  logic                  i_full,
    output logic                  o_push,
    output tlfo_pkg::t_item       o_item
);

    logic r_btn_high, n_btn_high;
    logic r_cv_high, n_cv_high;
    logic toggle;
    logic signed [18:0] rcv5;
    logic signed [16:0] rcv_q;
    logic signed [19:0] pitch_raw;
    logic [13:0] pitch;
    logic [11:0] fr;
    logic [tlfo_pkg::EXP_TABLE_BITS:0] idx;
    logic [11:0] frac;
    logic [17:0] ea, eb;
    logic [29:0] ed;
    logic [17:0] e;
    logic [20:0] freq;
    logic signed [22:0] wsum;
    logic signed [18:0] bsum;
    logic [16:0] wave, blend;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        toggle     = 1'b0;
        n_btn_high = i_bypass_button;
        n_cv_high  = r_cv_high;
        if (i_bypass_button && !r_btn_high) begin
            toggle = 1'b1;
        end
        if (!toggle) begin
            if (!r_cv_high) begin
                if (i_bypass_cv >= tlfo_pkg::TRIG_HIGH) begin
                    n_cv_high = 1'b1;
                    toggle    = 1'b1;
                end
            end else if (i_bypass_cv <= 16'sd0) begin
                n_cv_high = 1'b0;
            end
        end
    end

    always_comb begin
        rcv5      = {{3{i_rate_cv[15]}}, i_rate_cv} * 19'sd5;
        rcv_q     = 17'(rcv5 >>> 2);
        pitch_raw = $signed({6'd0, i_cfg.rate_knob}) + {{3{rcv_q[16]}}, rcv_q};
        if (pitch_raw < 20'sd0) begin
            pitch = 14'd0;
        end else if (pitch_raw > $signed({6'd0, tlfo_pkg::RATE_MAX})) begin
            pitch = tlfo_pkg::RATE_MAX;
        end else begin
            pitch = pitch_raw[13:0];
        end
        fr   = pitch[11:0];
        idx  = (tlfo_pkg::EXP_TABLE_BITS + 1)'(fr >> tlfo_pkg::EXP_SHIFT);
        frac = fr & 12'((1 << tlfo_pkg::EXP_SHIFT) - 1);
        ea   = tlfo_pkg::EXP_ROM[idx];
        eb   = tlfo_pkg::EXP_ROM[idx + 1'b1];
        ed   = 30'(eb - ea) * 30'(frac);
        e    = ea + 18'(ed >> tlfo_pkg::EXP_SHIFT);
        freq = 21'(e) << pitch[13:12];

        wsum = $signed({6'd0, i_cfg.wave_knob}) + {{7{i_wave_cv[15]}}, i_wave_cv} * 23'sd20;
        if (wsum < 23'sd0) begin
            wave = 17'd0;
        end else if (wsum > $signed({6'd0, tlfo_pkg::FULL})) begin
            wave = tlfo_pkg::FULL;
        end else begin
            wave = wsum[16:0];
        end
        bsum = $signed({2'd0, i_cfg.blend_knob}) + {{2{i_blend_cv[15]}}, i_blend_cv, 1'b0};
        if (bsum < 19'sd0) begin
            blend = 17'd0;
        end else if (bsum > $signed({2'd0, tlfo_pkg::FULL})) begin
            blend = tlfo_pkg::FULL;
        end else begin
            blend = bsum[16:0];
        end
    end

    always_comb begin
        o_item.x      = i_audio_in;
        o_item.freq   = freq;
        o_item.wave   = wave;
        o_item.blend  = blend;
        o_item.toggle = toggle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_high <= 1'b0;
            r_cv_high  <= 1'b0;
        end else if (o_push) begin
            r_btn_high <= n_btn_high;
            r_cv_high  <= n_cv_high;
        end
    end

endmodule

// File: rtl/tlfo_queue.sv
// two-entry queue between front end and back end
module tlfo_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tlfo_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output tlfo_pkg::t_item o_item
);

    tlfo_pkg::t_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// File: rtl/tlfo_back.sv
// back end: lfo phase and shape, tremolo, blend and bypass fade on one shared multiplier
module tlfo_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlfo_pkg::t_cfg     i_cfg,
    input  logic               i_empty,
    input  tlfo_pkg::t_item    i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_audio_out
);

    localparam int CS = tlfo_pkg::COS_SHIFT;
    localparam int CB = tlfo_pkg::COS_TABLE_BITS;
    localparam int MW = tlfo_pkg::MUL_W;
    localparam int PW = tlfo_pkg::PROD_W;

    tlfo_pkg::t_state r_state, n_state;
    tlfo_pkg::t_item  r_item;
    logic [31:0] r_phase;
    logic r_byp;
    logic [16:0] r_in_fx, r_in_dry, r_out_fx, r_out_dry;
    logic signed [PW-1:0] r_prod, r_acc;
    logic signed [18:0] r_a;
    logic r_neg;
    logic signed [17:0] r_mix;
    logic r_out_valid;
    logic signed [15:0] r_out;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] product;
    logic [35:0] p16;
    logic [31:0] dlt;
    logic [CB-1:0] k;
    logic signed [18:0] ca, cb, cmag, c, gs, gt, d, dmag, g, lv;
    logic signed [39:0] trem, mixr, yr;
    logic signed [17:0] mix;
    logic [16:0] lvl_dry, lvl_fx;
    logic nb;
    logic [16:0] b_in_fx, b_in_dry, b_out_fx, b_out_dry;
    logic [17:0] up_sum;
    logic signed [18:0] dn_sum;
    logic load_out;

    function automatic logic signed [18:0] f_cos_at(logic [CB-1:0] kk);
        logic [CB-3:0] rr;
        logic [CB-2:0] mirror;
        rr     = kk[CB-3:0];
        mirror = (CB-1)'(tlfo_pkg::COS_QUARTER) - (CB-1)'(rr);
        case (kk[CB-1:CB-2])
            2'd0:    return  $signed({2'b0, tlfo_pkg::COS_ROM[rr]});
            2'd1:    return -$signed({2'b0, tlfo_pkg::COS_ROM[mirror]});
            2'd2:    return -$signed({2'b0, tlfo_pkg::COS_ROM[rr]});
            default: return  $signed({2'b0, tlfo_pkg::COS_ROM[mirror]});
        endcase
    endfunction

    function automatic logic signed [39:0] f_rnd16(logic signed [PW:0] v);
        logic signed [PW:0] t;
        t = v + (PW+1)'(32768);
        return 40'(t >>> 16);
    endfunction

    assign o_valid     = r_out_valid;
    assign o_audio_out = r_out;
    assign product     = mul_a * mul_b;
    assign o_pop       = (r_state == tlfo_pkg::ST_IDLE) && !i_empty;
    assign lvl_dry     = r_byp ? r_in_dry : r_out_dry;
    assign lvl_fx      = r_byp ? r_out_fx : r_in_fx;

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        p16    = r_prod[51:16];
        dlt    = (p16 > 36'h080000000) ? 32'h80000000 : p16[31:0];
        k      = r_phase[31:CS];
        ca     = f_cos_at(k);
        cb     = f_cos_at(k + 1'b1);
        cmag   = (cb >= ca) ? cb - ca : ca - cb;
        lv     = $signed({1'b0, r_prod[CS+17:CS]});
        c      = r_neg ? r_a - lv : r_a + lv;
        gs     = (19'sd65536 - c) >>> 1;
        gt     = r_phase[31] ? $signed({2'b0, 17'((33'h100000000 - 33'(r_phase)) >> 15)})
                             : $signed({2'b0, 17'(r_phase >> 15)});
        d      = gt - gs;
        dmag   = (d < 0) ? -d : d;
        g      = r_neg ? r_a - $signed({2'b0, r_prod[32:16]})
                       : r_a + $signed({2'b0, r_prod[32:16]});
        if (!i_cfg.phase_switch) begin
            g = 19'sd65536 - g;
        end
        trem   = f_rnd16({r_prod[PW-1], r_prod});
        mixr   = f_rnd16({r_prod[PW-1], r_prod});
        mix    = 18'(r_item.x) + 18'(mixr);
        yr     = f_rnd16(PW'(r_acc) + (PW+1)'(r_prod));
        case (r_state)
            tlfo_pkg::ST_FREQ: begin
                mul_a = $signed(MW'(r_item.freq));
                mul_b = $signed(MW'(i_cfg.phase_step_per_hz));
            end
            tlfo_pkg::ST_COS: begin
                mul_a = MW'(cmag);
                mul_b = $signed(MW'(r_phase[CS-1:0]));
            end
            tlfo_pkg::ST_WAVE: begin
                mul_a = MW'(dmag);
                mul_b = $signed(MW'(r_item.wave));
            end
            tlfo_pkg::ST_TREM: begin
                mul_a = MW'(r_item.x);
                mul_b = MW'(g);
            end
            tlfo_pkg::ST_MIX: begin
                mul_a = MW'(18'(trem) - 18'(r_item.x));
                mul_b = $signed(MW'(r_item.blend));
            end
            tlfo_pkg::ST_DRY: begin
                mul_a = MW'(r_item.x);
                mul_b = $signed(MW'(lvl_dry));
            end
            tlfo_pkg::ST_FX: begin
                mul_a = MW'(r_mix);
                mul_b = $signed(MW'(lvl_fx));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // fade levels for a newly taken beat
    always_comb begin
        nb        = r_byp ^ i_item.toggle;
        b_in_fx   = i_item.toggle ? 17'd0 : r_in_fx;
        b_in_dry  = i_item.toggle ? 17'd0 : r_in_dry;
        b_out_fx  = i_item.toggle ? tlfo_pkg::FULL : r_out_fx;
        b_out_dry = i_item.toggle ? tlfo_pkg::FULL : r_out_dry;
        up_sum    = (nb ? {1'b0, b_in_dry} : {1'b0, b_in_fx}) + {1'b0, i_cfg.fade_step};
        dn_sum    = (nb ? $signed({2'b0, b_out_fx}) : $signed({2'b0, b_out_dry}))
                    - $signed({2'b0, i_cfg.fade_step});
        if (up_sum > {1'b0, tlfo_pkg::FULL}) begin
            up_sum = {1'b0, tlfo_pkg::FULL};
        end
        if (dn_sum < 0) begin
            dn_sum = '0;
        end
    end

    assign load_out = (r_state == tlfo_pkg::ST_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            tlfo_pkg::ST_IDLE:  if (!i_empty) n_state = tlfo_pkg::ST_FREQ;
            tlfo_pkg::ST_FREQ:  n_state = tlfo_pkg::ST_PHASE;
            tlfo_pkg::ST_PHASE: n_state = tlfo_pkg::ST_COS;
            tlfo_pkg::ST_COS:   n_state = tlfo_pkg::ST_WAVE;
            tlfo_pkg::ST_WAVE:  n_state = tlfo_pkg::ST_TREM;
            tlfo_pkg::ST_TREM:  n_state = tlfo_pkg::ST_MIX;
            tlfo_pkg::ST_MIX:   n_state = tlfo_pkg::ST_DRY;
            tlfo_pkg::ST_DRY:   n_state = tlfo_pkg::ST_FX;
            tlfo_pkg::ST_FX:    n_state = tlfo_pkg::ST_DONE;
            tlfo_pkg::ST_DONE:  if (load_out) n_state = tlfo_pkg::ST_IDLE;
            default:            n_state = tlfo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state != tlfo_pkg::ST_DONE) begin
            r_prod <= product;
        end
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == tlfo_pkg::ST_COS) begin
            r_a   <= ca;
            r_neg <= (cb < ca);
        end
        if (r_state == tlfo_pkg::ST_WAVE) begin
            r_a   <= gs;
            r_neg <= (d < 0);
        end
        if (r_state == tlfo_pkg::ST_DRY) begin
            r_mix <= mix;
        end
        if (r_state == tlfo_pkg::ST_FX) begin
            r_acc <= r_prod;
        end
        if (load_out) begin
            if (yr > 40'sd32767) begin
                r_out <= 16'sh7FFF;
            end else if (yr < -40'sd32768) begin
                r_out <= 16'sh8000;
            end else begin
                r_out <= 16'(yr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlfo_pkg::ST_IDLE;
            r_phase     <= 32'd0;
            r_byp       <= 1'b0;
            r_in_fx     <= 17'd0;
            r_in_dry    <= 17'd0;
            r_out_fx    <= tlfo_pkg::FULL;
            r_out_dry   <= tlfo_pkg::FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tlfo_pkg::ST_PHASE) begin
                r_phase <= r_phase + dlt;
            end
            if (o_pop) begin
                r_byp <= nb;
                if (nb) begin
                    r_in_fx   <= b_in_fx;
                    r_out_dry <= b_out_dry;
                    r_in_dry  <= up_sum[16:0];
                    r_out_fx  <= dn_sum[16:0];
                end else begin
                    r_in_dry  <= b_in_dry;
                    r_out_fx  <= b_out_fx;
                    r_in_fx   <= up_sum[16:0];
                    r_out_dry <= dn_sum[16:0];
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/tremolo_lfo_with_bypass_fade.sv
// top level of the tremolo effect with bypass cross-fade
//
// Input channel: one beat per audio sample (i_in_valid / o_in_ready) carrying the
// sample, the wave, rate and blend control voltages, the bypass trigger voltage
// and the bypass button level. Output channel: one processed sample per input
// beat (o_out_valid / i_out_ready), in order.
// A front end clamps the controls, looks up the lfo frequency and runs the
// bypass edge detectors; a two-beat queue feeds the back end, which steps
// through phase update, cosine, wave mix, tremolo, blend and the two fade
// products on one shared multiplier.
// The back end takes a new beat from the queue only once it has passed the previous
// one to the output register and returned to idle.
// Reset (synchronous, active low) empties the queue and output register,
// clears the lfo phase and the bypass state and restores register defaults.
// When the receiver stalls, the result holds; the queue still takes up to two
// more beats and the back end finishes one more, then o_in_ready drops.
// Registers are written over the APB port at byte address 4 * index.
module tremolo_lfo_with_bypass_fade (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_audio_in,
    input  logic signed [15:0] i_wave_cv,
    input  logic signed [15:0] i_rate_cv,
    input  logic signed [15:0] i_blend_cv,
    input  logic signed [15:0] i_bypass_cv,
    input  logic               i_bypass_button,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_audio_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    tlfo_pkg::t_cfg  r_cfg;
    tlfo_pkg::t_item f_item, q_item;
    logic push, pop, full, empty, wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_knob         <= 14'd7168;
            r_cfg.wave_knob         <= 17'd32768;
            r_cfg.blend_knob        <= 17'd32768;
            r_cfg.phase_switch      <= 1'b1;
            r_cfg.phase_step_per_hz <= 24'd89478;
            r_cfg.fade_step         <= 17'd66;
        end else if (wr) begin
            case (paddr[4:2])
                tlfo_pkg::REG_RATE:  r_cfg.rate_knob         <= pwdata[13:0];
                tlfo_pkg::REG_WAVE:  r_cfg.wave_knob         <= pwdata[16:0];
                tlfo_pkg::REG_BLEND: r_cfg.blend_knob        <= pwdata[16:0];
                tlfo_pkg::REG_PHASE: r_cfg.phase_switch      <= pwdata[0];
                tlfo_pkg::REG_STEP:  r_cfg.phase_step_per_hz <= pwdata[23:0];
                tlfo_pkg::REG_FADE:  r_cfg.fade_step         <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            tlfo_pkg::REG_RATE:  prdata = {18'd0, r_cfg.rate_knob};
            tlfo_pkg::REG_WAVE:  prdata = {15'd0, r_cfg.wave_knob};
            tlfo_pkg::REG_BLEND: prdata = {15'd0, r_cfg.blend_knob};
            tlfo_pkg::REG_PHASE: prdata = {31'd0, r_cfg.phase_switch};
            tlfo_pkg::REG_STEP:  prdata = {8'd0, r_cfg.phase_step_per_hz};
            tlfo_pkg::REG_FADE:  prdata = {15'd0, r_cfg.fade_step};
            default:             prdata = 32'd0;
        endcase
    end

    tlfo_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_audio_in      (i_audio_in),
        .i_wave_cv       (i_wave_cv),
        .i_rate_cv       (i_rate_cv),
        .i_blend_cv      (i_blend_cv),
        .i_bypass_cv     (i_bypass_cv),
        .i_bypass_button (i_bypass_button),
        .i_cfg           (r_cfg),
        .i_full          (full),
        .o_push          (push),
        .o_item          (f_item)
    );

    tlfo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (q_item)
    );

    tlfo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (empty),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_audio_out (o_audio_out)
    );

endmodule

// File: rtl/tlfo_checker.sv
// port-level checks of the tremolo block, bound to the top level
module tlfo_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_audio_out,
    input logic               pready
);

    a_reset_no_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output beat shown right after reset");

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_audio_out))
        else $error("stalled output beat changed");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind tremolo_lfo_with_bypass_fade tlfo_checker u_tlfo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_audio_out (o_audio_out),
    .pready      (pready)
);

// File: verif/tremolo_lfo_with_bypass_fade_test.sv
// testbench of the tremolo effect: directed and random samples checked against a predictor
module tremolo_lfo_with_bypass_fade_test;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 30;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_audio_in;
    logic signed [15:0] i_wave_cv;
    logic signed [15:0] i_rate_cv;
    logic signed [15:0] i_blend_cv;
    logic signed [15:0] i_bypass_cv;
    logic               i_bypass_button;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_audio_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    tremolo_lfo_with_bypass_fade dut (.*);

    // predictor state and register copies
    longint unsigned cos_tab [tlfo_pkg::COS_QUARTER + 1];
    longint unsigned exp_tab [tlfo_pkg::EXP_SIZE + 1];
    longint rate_knob, wave_knob, blend_knob, phase_switch, step_per_hz, fade_step;
    longint unsigned lfo_phase;
    bit     bypassed, btn_high, trig_high;
    longint in_fx, in_dry, out_fx, out_dry;

    logic signed [15:0] expected_audio [$];
    int  fail_count;
    int  cycle_count;
    bit  calm;
    bit  btn_level;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint q16_round(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint interp(longint a, longint b, longint unsigned f, int s);
        longint unsigned d;
        if (b >= a) begin
            d = longint'(b - a) * f;
            return a + longint'(d >> s);
        end
        d = longint'(a - b) * f;
        return a - longint'(d >> s);
    endfunction

    function automatic void build_tables();
        longint unsigned x, x2, term, y, usum;
        longint sum;
        for (int i = 0; i <= tlfo_pkg::COS_QUARTER; i++) begin
            x    = (longint'(i) * 64'd1686629713) / tlfo_pkg::COS_QUARTER;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = 64'sd1 <<< 30;
            for (int k = 1; k <= 10; k++) begin
                term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            cos_tab[i] = sum <= 0 ? 0 : clip((sum + 8192) >>> 14, 0, 65536);
        end
        for (int j = 0; j <= tlfo_pkg::EXP_SIZE; j++) begin
            y    = (longint'(j) * 64'd744261118) >> tlfo_pkg::EXP_TABLE_BITS;
            term = 64'd1 << 30;
            usum = term;
            for (int k = 1; k <= 16; k++) begin
                term = ((term * y) >> 30) / longint'(k);
                usum = usum + term;
            end
            exp_tab[j] = (usum + 8192) >> 14;
        end
    endfunction

    function automatic longint cos_lookup(longint unsigned k);
        longint unsigned q, r;
        k = k & (4 * tlfo_pkg::COS_QUARTER - 1);
        q = k / tlfo_pkg::COS_QUARTER;
        r = k % tlfo_pkg::COS_QUARTER;
        case (q)
            0: return longint'(cos_tab[r]);
            1: return -longint'(cos_tab[tlfo_pkg::COS_QUARTER - r]);
            2: return -longint'(cos_tab[r]);
            default: return longint'(cos_tab[tlfo_pkg::COS_QUARTER - r]);
        endcase
    endfunction

    function automatic void reset_predictor();
        rate_knob = 7168; wave_knob = 32768; blend_knob = 32768;
        phase_switch = 1; step_per_hz = 89478; fade_step = 66;
        lfo_phase = 0; bypassed = 0; btn_high = 0; trig_high = 0;
        in_fx = 0; in_dry = 0; out_fx = 65536; out_dry = 65536;
    endfunction

    function automatic logic signed [15:0] tremolo_sample(longint x, longint wcv, longint rcv,
                                                          longint bcv, longint tcv, bit btn);
        bit toggle;
        longint pitch, fr, idx, e, c, gs, gt, wave, g, trem, blend, mix, y;
        longint unsigned freq, delta, k, cf;
        toggle = btn && !btn_high;
        btn_high = btn;
        if (!toggle) begin
            if (!trig_high) begin
                if (tcv >= 3277) begin
                    trig_high = 1;
                    toggle = 1;
                end
            end else if (tcv <= 0) begin
                trig_high = 0;
            end
        end
        if (toggle) begin
            bypassed = !bypassed;
            in_fx = 0; in_dry = 0; out_fx = 65536; out_dry = 65536;
        end
        pitch = clip(rate_knob + ((rcv * 5) >>> 2), 0, 14336);
        fr    = pitch & 4095;
        idx   = fr >> tlfo_pkg::EXP_SHIFT;
        e     = interp(exp_tab[idx], exp_tab[idx + 1],
                       fr & ((1 << tlfo_pkg::EXP_SHIFT) - 1), tlfo_pkg::EXP_SHIFT);
        freq  = longint'(e) << (pitch >> 12);
        delta = (freq * longint'(step_per_hz)) >> 16;
        if (delta > 64'h8000_0000) begin
            delta = 64'h8000_0000;
        end
        lfo_phase = (lfo_phase + delta) & 64'hFFFF_FFFF;
        k  = lfo_phase >> tlfo_pkg::COS_SHIFT;
        cf = lfo_phase & ((64'd1 << tlfo_pkg::COS_SHIFT) - 1);
        c  = interp(cos_lookup(k), cos_lookup(k + 1), cf, tlfo_pkg::COS_SHIFT);
        gs = (65536 - c) >>> 1;
        gt = lfo_phase < 64'h8000_0000 ? longint'(lfo_phase >> 15)
                                       : longint'((64'h1_0000_0000 - lfo_phase) >> 15);
        wave = clip(wave_knob + 20 * wcv, 0, 65536);
        g    = gs + interp(0, gt - gs, wave, 16);
        if (phase_switch == 0) begin
            g = 65536 - g;
        end
        trem  = q16_round(x * g);
        blend = clip(blend_knob + 2 * bcv, 0, 65536);
        mix   = x + q16_round((trem - x) * blend);
        if (bypassed) begin
            in_dry = clip(in_dry + fade_step, 0, 65536);
            out_fx = clip(out_fx - fade_step, 0, 65536);
            y = q16_round(x * in_dry + mix * out_fx);
        end else begin
            in_fx   = clip(in_fx + fade_step, 0, 65536);
            out_dry = clip(out_dry - fade_step, 0, 65536);
            y = q16_round(x * out_dry + mix * in_fx);
        end
        return 16'(clip(y, -32768, 32767));
    endfunction

    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] wcv,
                               logic signed [15:0] rcv, logic signed [15:0] bcv,
                               logic signed [15:0] tcv, logic btn);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_audio_in      <= x;
        i_wave_cv       <= wcv;
        i_rate_cv       <= rcv;
        i_blend_cv      <= bcv;
        i_bypass_cv     <= tcv;
        i_bypass_button <= btn;
        do @(posedge i_clk); while (!o_in_ready);
        expected_audio.push_back(tremolo_sample(x, wcv, rcv, bcv, tcv, btn));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_audio.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tlfo_pkg::REG_RATE:  rate_knob    = value & 32'h3FFF;
            tlfo_pkg::REG_WAVE:  wave_knob    = value & 32'h1FFFF;
            tlfo_pkg::REG_BLEND: blend_knob   = value & 32'h1FFFF;
            tlfo_pkg::REG_PHASE: phase_switch = value & 32'h1;
            tlfo_pkg::REG_STEP:  step_per_hz  = value & 32'hFFFFFF;
            tlfo_pkg::REG_FADE:  fade_step    = value & 32'h1FFFF;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] r, logic [31:0] w, logic [31:0] b,
                             logic [31:0] p, logic [31:0] s, logic [31:0] f);
        write_reg(tlfo_pkg::REG_RATE, r);
        write_reg(tlfo_pkg::REG_WAVE, w);
        write_reg(tlfo_pkg::REG_BLEND, b);
        write_reg(tlfo_pkg::REG_PHASE, p);
        write_reg(tlfo_pkg::REG_STEP, s);
        write_reg(tlfo_pkg::REG_FADE, f);
    endtask

    function automatic logic signed [15:0] rand_cv();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed(16'($urandom_range(0, 6000))) - 16'sd3000);
            2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'sd0;
        endcase
    endfunction

    task automatic send_random(int n);
        logic signed [15:0] tcv;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 40) == 0) begin
                btn_level = !btn_level;
            end
            case ($urandom_range(0, 9))
                0: tcv = 16'($urandom);
                1: tcv = 16'sd3277 + 16'($urandom_range(0, 20000));
                default: tcv = -16'sd5 + 16'($urandom_range(0, 10));
            endcase
            send_sample(16'($urandom), rand_cv(), rand_cv(), rand_cv(), tcv, btn_level);
        end
    endtask

    task automatic test_directed();
        send_sample(16'sh7FFF, 0, 0, 0, 0, 0);
        send_sample(16'sh8000, 0, 0, 0, 0, 0);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0);
        send_sample(16'sh1234, 0, 0, 0, 16'sd3276, 0);
        // trigger edge, hold, release, then rearm
        send_sample(16'sh4000, 0, 0, 0, 16'sd3277, 0);
        send_sample(16'sh4000, 0, 0, 0, 16'sd1, 0);
        send_sample(-16'sh4000, 0, 0, 0, 16'sd0, 0);
        send_sample(16'sh7000, 0, 0, 0, 16'sh7FFF, 0);
        send_sample(16'sh7000, 0, 0, 0, 16'sh8000, 0);
        // button edge takes priority over the trigger
        send_sample(16'sh2000, 0, 0, 0, 16'sd4000, 1);
        send_sample(16'sh2000, 0, 0, 0, 16'sd4000, 1);
        send_sample(16'sh2000, 0, 0, 0, 16'sd0, 0);
        send_sample(16'sh2000, 0, 0, 0, 16'sd0, 1);
        send_sample(16'sh0001, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 0);
        send_sample(-16'sd1, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 1);
        send_sample(0, 0, 0, 0, 0, 0);
        btn_level = 0;
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_all(0, 0, 0, 0, 1, 0);
        send_random(60);
        wait_drained();
        write_all(32'h3FFF, 32'h1FFFF, 32'h1FFFF, 1, 32'hFFFFFF, 32'h1FFFF);
        send_random(60);
        wait_drained();
        write_all(14336, 65536, 65536, 0, 32'hFFFFFF, 1);
        send_random(60);
        wait_drained();
        write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 32'hFFFFFFFF);
        send_random(60);
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 12; p++) begin
            write_all($urandom_range(0, 16383), $urandom_range(0, 131071),
                      $urandom_range(0, 131071), $urandom_range(0, 1),
                      $urandom_range(1, 16777215), $urandom_range(0, 131071));
            calm = (p % 3 == 0);
            send_random(60);
            calm = 0;
            wait_drained();
        end
    endtask

    task automatic test_long_fades();
        write_all(7168, 32768, 32768, 1, 89478, 66);
        send_random(400);
        // sender holds off until the queue runs dry
        wait_drained();
        write_reg(tlfo_pkg::REG_FADE, 4000);
        calm = 1;
        send_random(200);
        calm = 0;
        send_random(200);
        wait_drained();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_audio_in      <= '0;
        i_wave_cv       <= '0;
        i_rate_cv       <= '0;
        i_blend_cv      <= '0;
        i_bypass_cv     <= '0;
        i_bypass_button <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        fail_count = 0;
        calm       = 0;
        btn_level  = 0;
        build_tables();
        reset_predictor();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_random_settings();
        test_long_fades();
        if (fail_count == 0) begin
            $display("tremolo_lfo_with_bypass_fade test passed");
        end else begin
            $display("tremolo_lfo_with_bypass_fade test failed");
        end
        $finish;
    end

    // receiver with random stalls
    initial begin
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_audio.size() == 0) begin
                $display("%0t: unexpected beat, actual %0d", $time, o_audio_out);
                fail_count++;
            end else begin
                if (o_audio_out !== expected_audio[0]) begin
                    $display("%0t: audio_out expected %0d actual %0d",
                             $time, expected_audio[0], o_audio_out);
                    fail_count++;
                end
                void'(expected_audio.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tremolo_lfo_with_bypass_fade test failed");
            $finish;
        end
    end

endmodule
